// ===== rtl/sprd_pkg.sv =====
// ============================================================================
// sprd_pkg: shared types and constants for the sprite run-length decoder
// Register indexes, result kinds, the raw result record passed from the
// decoder to the output stage, and sizing constants.
// ============================================================================
package sprd_pkg;

    localparam int SPRITE_SIDE_DEF = 32;
    localparam int SPRITE_SIDE_MAX = 64;

    // Index and length fields sized for the largest supported sprite
    localparam int RAW_W = $clog2(SPRITE_SIDE_MAX * SPRITE_SIDE_MAX + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int COLOR_W    = 32;
    localparam int ORIGIN_W   = 12;
    localparam int COORD_W    = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_KEY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd3;

    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_KEY = 1'b1;

    // Result queue depth between decoder and output stage
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [COLOR_W-1:0]  background_color;
        logic                read_color_key;
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic [RAW_W-1:0]   idx;
        logic [RAW_W-1:0]   len;
        logic [COLOR_W-1:0] color;
        logic               transp;
        logic               done;
    } raw_result_t;

    // Up to two results per input byte; the second is always the closing fill
    typedef struct packed {
        logic        v0;
        logic        v1;
        raw_result_t r0;
        raw_result_t r1;
    } push_t;

endpackage

// ===== rtl/sprd_if.sv =====
// ============================================================================
// sprd interfaces: record byte, result and configuration channels
// Valid/ready channels; a transaction completes when both are high.
// ============================================================================
interface sprd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       record_start;

    modport source (output valid, output data_byte, output record_start, input ready);
    modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface sprd_out_if #(
    parameter int RUN_W = 11
);
    logic             valid;
    logic             ready;
    logic             kind;
    logic [12:0]      start_x;
    logic [12:0]      start_y;
    logic [RUN_W-1:0] run_length;
    logic [31:0]      pixel_color;
    logic             is_transparent;
    logic             sprite_done;

    modport source (output valid, output kind, output start_x, output start_y,
                    output run_length, output pixel_color, output is_transparent,
                    output sprite_done, input ready);
    modport sink   (input valid, input kind, input start_x, input start_y,
                    input run_length, input pixel_color, input is_transparent,
                    input sprite_done, output ready);
endinterface

interface sprd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sprite_rle_decoder_core.sv =====
// ============================================================================
// sprite_rle_decoder_core: alternating run-length sprite decoder
// Decodes sprite records one byte at a time into pixel runs, colour pixels,
// colour key results and a closing background fill.
//
//   channel   dir  payload                                        handshake
//   record    in   data_byte[7:0], record_start                   valid/ready
//   result    out  kind, start_x, start_y, run_length,            valid/ready
//                  pixel_color, is_transparent, sprite_done
//   cfg       in   index[1:0], data[31:0]                         valid/ready
//
// One byte per cycle is accepted while the queue has room; a byte makes up
// to two results, which leave through a 4-entry result queue at one per
// cycle while result.ready allows. A byte passes the input register, the
// queue, the reciprocal multiply stage and the coordinate/output register.
// The record channel stalls only while the queue cannot take two results.
// Reset (rst_n low, async) empties all stages and returns the parser to
// waiting for a record start; control state resets (transparent flag to one).
// ============================================================================
module sprite_rle_decoder_core #(
    parameter int SPRITE_SIDE = sprd_pkg::SPRITE_SIDE_DEF,
    parameter int RUN_W       = $clog2(SPRITE_SIDE * SPRITE_SIDE + 1)
) (
    input  logic        clk,
    input  logic        rst_n,
    sprd_in_if.sink     record,
    sprd_out_if.source  result,
    sprd_cfg_if.sink    cfg
);
    import sprd_pkg::*;

    cfg_t  cfg_reg;
    logic  room;
    push_t push;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BACKGROUND: cfg_reg.background_color <= cfg.data;
                CFG_READ_KEY:   cfg_reg.read_color_key   <= cfg.data[0];
                CFG_ORIGIN_X:   cfg_reg.origin_x         <= cfg.data[ORIGIN_W-1:0];
                CFG_ORIGIN_Y:   cfg_reg.origin_y         <= cfg.data[ORIGIN_W-1:0];
                default:        cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    sprd_decode #(
        .SPRITE_SIDE (SPRITE_SIDE)
    ) u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .record (record),
        .cfg    (cfg_reg),
        .room   (room),
        .push   (push)
    );

    sprd_out #(
        .SPRITE_SIDE (SPRITE_SIDE),
        .RUN_W       (RUN_W)
    ) u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cfg    (cfg_reg),
        .room   (room),
        .result (result)
    );

endmodule

// ===== rtl/sprd_decode.sv =====
// ============================================================================
// sprd_decode: input register and record parser
// Registers one record byte, then walks header, counts and colour triples,
// producing up to two raw results per byte into the result queue.
// ============================================================================
module sprd_decode #(
    parameter int SPRITE_SIDE = sprd_pkg::SPRITE_SIDE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    sprd_in_if.sink             record,
    input  sprd_pkg::cfg_t      cfg,
    input  logic                room,
    output sprd_pkg::push_t     push
);
    import sprd_pkg::*;

    localparam int PIXELS      = SPRITE_SIDE * SPRITE_SIDE;
    localparam int SIZE_LIMIT  = 6 * PIXELS;
    localparam int COUNT_LIMIT = 3 * PIXELS;
    localparam int IDX_W       = $clog2(PIXELS + 1);
    localparam int SIZE_W      = $clog2(SIZE_LIMIT + 1);
    localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_KEY,
        PH_SIZE_LO,
        PH_SIZE_HI,
        PH_CNT_LO,
        PH_CNT_HI,
        PH_PIX
    } phase_t;

    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic             start_reg;
    logic             fire;

    phase_t           phase_reg, phase_next;
    logic [SIZE_W-1:0] rsz_reg, rsz_next;
    logic [CNT_W-1:0] cc_reg, cc_next;
    logic             transp_reg, transp_next;
    logic [IDX_W-1:0] pix_reg, pix_next;
    logic [1:0]       bp_reg, bp_next;
    logic [23:0]      gather_reg, gather_next;
    logic [7:0]       hold_reg, hold_next;
    push_t            push_next;

    assign fire         = in_valid_reg && room;
    assign record.ready = !in_valid_reg || fire;
    assign push         = push_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (record.ready)
        begin
            in_valid_reg <= record.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (record.ready && record.valid)
        begin
            byte_reg  <= record.data_byte;
            start_reg <= record.record_start;
        end
    end

    always_comb
    begin
        logic [15:0]      word;
        logic [IDX_W-1:0] room_px;
        logic [IDX_W-1:0] len;
        logic             fill_req;
        raw_result_t      r;

        word      = {byte_reg, hold_reg};
        room_px   = IDX_W'(PIXELS) - pix_reg;
        len       = '0;
        fill_req  = 1'b0;
        r         = '0;

        phase_next  = phase_reg;
        rsz_next    = rsz_reg;
        cc_next     = cc_reg;
        transp_next = transp_reg;
        pix_next    = pix_reg;
        bp_next     = bp_reg;
        gather_next = gather_reg;
        hold_next   = hold_reg;
        push_next   = '0;

        if (fire)
        begin
            if (start_reg)
            begin
                rsz_next    = '0;
                cc_next     = '0;
                transp_next = 1'b1;
                pix_next    = '0;
                bp_next     = '0;
                gather_next = '0;
                phase_next  = cfg.read_color_key ? PH_KEY : PH_SIZE_LO;
            end

            case (phase_next)
                PH_KEY:
                begin
                    gather_next = {gather_next[15:0], byte_reg};
                    if (bp_next == 2'd2)
                    begin
                        bp_next      = '0;
                        r.kind       = KIND_KEY;
                        r.color      = {8'h00, gather_next};
                        push_next.r0 = r;
                        push_next.v0 = 1'b1;
                        phase_next   = PH_SIZE_LO;
                    end
                    else
                    begin
                        bp_next = bp_next + 2'd1;
                    end
                end
                PH_SIZE_LO:
                begin
                    hold_next  = byte_reg;
                    phase_next = PH_SIZE_HI;
                end
                PH_SIZE_HI:
                begin
                    if (word == 16'd0 || word > 16'(SIZE_LIMIT))
                    begin
                        r.kind       = KIND_RUN;
                        r.len        = RAW_W'(PIXELS);
                        r.color      = cfg.background_color;
                        r.transp     = 1'b1;
                        r.done       = 1'b1;
                        push_next.r0 = r;
                        push_next.v0 = 1'b1;
                        pix_next     = IDX_W'(PIXELS);
                        phase_next   = PH_IDLE;
                    end
                    else
                    begin
                        rsz_next   = SIZE_W'(word);
                        phase_next = PH_CNT_LO;
                    end
                end
                PH_CNT_LO:
                begin
                    hold_next  = byte_reg;
                    phase_next = PH_CNT_HI;
                end
                PH_CNT_HI:
                begin
                    if (word > 16'(COUNT_LIMIT))
                    begin
                        fill_req = 1'b1;
                    end
                    else
                    begin
                        rsz_next = (rsz_next > SIZE_W'(2)) ? rsz_next - SIZE_W'(2) : '0;
                        cc_next  = CNT_W'(word);
                        if (transp_next)
                        begin
                            len = (word < 16'(room_px)) ? IDX_W'(word) : room_px;
                            if (len != '0)
                            begin
                                r.kind       = KIND_RUN;
                                r.idx        = RAW_W'(pix_next);
                                r.len        = RAW_W'(len);
                                r.color      = cfg.background_color;
                                r.transp     = 1'b1;
                                push_next.r0 = r;
                                push_next.v0 = 1'b1;
                                pix_next     = pix_next + len;
                            end
                            cc_next     = '0;
                            transp_next = 1'b0;
                            if (rsz_next == '0)
                                fill_req = 1'b1;
                            else
                                phase_next = PH_CNT_LO;
                        end
                        else if (word == 16'd0)
                        begin
                            transp_next = 1'b1;
                            if (rsz_next == '0)
                                fill_req = 1'b1;
                            else
                                phase_next = PH_CNT_LO;
                        end
                        else
                        begin
                            bp_next    = '0;
                            phase_next = PH_PIX;
                        end
                    end
                end
                PH_PIX:
                begin
                    gather_next = {gather_next[15:0], byte_reg};
                    if (bp_next == 2'd2)
                    begin
                        bp_next = '0;
                        if (pix_next != IDX_W'(PIXELS))
                        begin
                            r.kind       = KIND_RUN;
                            r.idx        = RAW_W'(pix_next);
                            r.len        = RAW_W'(1);
                            r.color      = {8'hFF, gather_next};
                            push_next.r0 = r;
                            push_next.v0 = 1'b1;
                            pix_next     = pix_next + IDX_W'(1);
                        end
                        rsz_next = (rsz_next > SIZE_W'(3)) ? rsz_next - SIZE_W'(3) : '0;
                        if (cc_next != '0)
                            cc_next = cc_next - CNT_W'(1);
                        if (cc_next == '0)
                        begin
                            transp_next = ~transp_next;
                            if (rsz_next == '0)
                                fill_req = 1'b1;
                            else
                                phase_next = PH_CNT_LO;
                        end
                    end
                    else
                    begin
                        bp_next = bp_next + 2'd1;
                    end
                end
                default:
                begin
                    // no record in progress: byte dropped
                end
            endcase

            // Closing fill of whatever is left of the sprite
            if (fill_req)
            begin
                push_next.r1.kind   = KIND_RUN;
                push_next.r1.idx    = RAW_W'(pix_next);
                push_next.r1.len    = RAW_W'(IDX_W'(PIXELS) - pix_next);
                push_next.r1.color  = cfg.background_color;
                push_next.r1.transp = 1'b1;
                push_next.r1.done   = 1'b1;
                push_next.v1        = 1'b1;
                pix_next            = IDX_W'(PIXELS);
                phase_next          = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            rsz_reg    <= '0;
            cc_reg     <= '0;
            transp_reg <= 1'b1;
            pix_reg    <= '0;
            bp_reg     <= '0;
            gather_reg <= '0;
            hold_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            rsz_reg    <= rsz_next;
            cc_reg     <= cc_next;
            transp_reg <= transp_next;
            pix_reg    <= pix_next;
            bp_reg     <= bp_next;
            gather_reg <= gather_next;
            hold_reg   <= hold_next;
        end
    end

    a_pix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pix_reg <= IDX_W'(PIXELS))
        else $error("pixel index beyond sprite");

    a_pix_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIX) |-> (cc_reg != '0))
        else $error("colour chunk active with zero count");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.v0 || push.v1) |-> room)
        else $error("results pushed without queue room");

endmodule

// ===== rtl/sprd_out.sv =====
// ============================================================================
// sprd_out: result queue and coordinate stage
// Queues raw results, splits the pixel index into row and column by a
// reciprocal multiply (one stage) and a correction (second stage).
// ============================================================================
module sprd_out #(
    parameter int SPRITE_SIDE = sprd_pkg::SPRITE_SIDE_DEF,
    parameter int RUN_W       = $clog2(SPRITE_SIDE * SPRITE_SIDE + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sprd_pkg::push_t push,
    input  sprd_pkg::cfg_t  cfg,
    output logic            room,
    sprd_out_if.source      result
);
    import sprd_pkg::*;

    localparam int PIXELS    = SPRITE_SIDE * SPRITE_SIDE;
    localparam int IDX_W     = $clog2(PIXELS + 1);
    localparam int Q_W       = $clog2(SPRITE_SIDE + 1);
    localparam int COL_W     = $clog2(SPRITE_SIDE);
    localparam int DIV_SHIFT = 24;
    localparam int RECIP     = (1 << DIV_SHIFT) / SPRITE_SIDE;
    localparam int PROD_W    = DIV_SHIFT + Q_W + 1;
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);

    raw_result_t      queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]       push_n;
    logic             pop;

    logic             a_valid_reg;
    raw_result_t      a_raw_reg;
    logic [Q_W-1:0]   a_q_reg;
    logic [PROD_W-1:0] prod;
    logic             a_load, b_load;

    logic [IDX_W-1:0] rem;
    logic [Q_W-1:0]   row;
    logic [COL_W-1:0] col;

    logic             out_valid_reg;

    assign room   = count_reg <= CNT_W'(QUEUE_DEPTH - 2);
    assign push_n = 2'(push.v0) + 2'(push.v1);
    assign b_load = !out_valid_reg || result.ready;
    assign a_load = !a_valid_reg || b_load;
    assign pop    = (count_reg != '0) && a_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    // Only the closing fill may arrive alone in the second slot
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            queue_mem[wr_ptr_reg] <= push.v0 ? push.r0 : push.r1;
        if (push_n == 2'd2)
            queue_mem[wr_ptr_reg + PTR_W'(1)] <= push.r1;
    end

    // Estimate is at most one below the true quotient
    assign prod = PROD_W'(queue_mem[rd_ptr_reg].idx) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_load)
            a_valid_reg <= (count_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_raw_reg <= queue_mem[rd_ptr_reg];
            a_q_reg   <= prod[DIV_SHIFT +: Q_W];
        end
    end

    always_comb
    begin
        rem = IDX_W'(a_raw_reg.idx) - IDX_W'(IDX_W'(a_q_reg) * IDX_W'(SPRITE_SIDE));
        if (rem >= IDX_W'(SPRITE_SIDE))
        begin
            row = a_q_reg + Q_W'(1);
            col = COL_W'(rem - IDX_W'(SPRITE_SIDE));
        end
        else
        begin
            row = a_q_reg;
            col = COL_W'(rem);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (b_load)
            out_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_load && a_valid_reg)
        begin
            result.kind           <= a_raw_reg.kind;
            result.start_x        <= COORD_W'(cfg.origin_x) + COORD_W'(col);
            result.start_y        <= COORD_W'(cfg.origin_y) + COORD_W'(row);
            result.run_length     <= RUN_W'(a_raw_reg.len);
            result.pixel_color    <= a_raw_reg.color;
            result.is_transparent <= a_raw_reg.transp;
            result.sprite_done    <= a_raw_reg.done;
        end
    end

    assign result.valid = out_valid_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("result queue underflow");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (rem < IDX_W'(2 * SPRITE_SIDE)))
        else $error("quotient estimate off by more than one");

endmodule
